>>> hw/rtl/byte_fifo_with_search_macros.svh
// assertion macros for the byte fifo with search
`ifndef BYTE_FIFO_WITH_SEARCH_MACROS_SVH
`define BYTE_FIFO_WITH_SEARCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define BFS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bfs_pkg.sv
package bfs_pkg;

   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_SEARCH  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       found;
      logic [1:0] status;
   } res_type;

endpackage

>>> hw/rtl/byte_fifo_with_search.sv
// Byte queue of DEPTH entries with enqueue, dequeue and membership search; one
// item is worked at a time and each item gives exactly one result. A search
// walks the queue from the head, reading one stored entry a cycle through the
// single read port of the entry memory, and stops at the first match or at the
// last held entry. Results sit in an output register, so the next item is
// accepted while a result waits to be taken.
module byte_fifo_with_search
   import bfs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_found,
   output logic [1:0] rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          out_free;
   logic          res_valid;
   res_type       res;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   logic          rsp_valid_ff, rsp_valid_in;
   res_type       rsp_ff;

   bfs_ctrl #(
      .DEPTH(DEPTH),
      .AW   (AW),
      .CW   (CW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_data_byte(req_data_byte),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res          (res),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   bfs_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_ff.out_byte;
   assign rsp_found    = rsp_ff.found;
   assign rsp_status   = rsp_ff.status;

endmodule

>>> hw/rtl/bfs_ram.sv
module bfs_ram
   import bfs_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bfs_ctrl.sv
`include "byte_fifo_with_search_macros.svh"

module bfs_ctrl
   import bfs_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_action,
   input  logic [7:0]    req_data_byte,
   input  logic          out_free,
   output logic          res_valid,
   output res_type       res,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   input  logic [7:0]    rd_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DEQ  = 2'd2;
   localparam logic [1:0] S_SRCH = 2'd3;

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   logic [1:0]    state_ff, state_in;
   logic [1:0]    act_ff, act_in;
   logic [7:0]    data_ff, data_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
      return (idx == LAST) ? '0 : idx + 1'b1;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign wr_addr   = tail_ff;
   assign wr_data   = data_ff;

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      data_in   = data_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      pos_in    = pos_ff;
      occ_in    = occ_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      res_valid = 1'b0;
      res       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               data_in  = req_data_byte;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (act_ff)
               ACT_ENQUEUE: begin
                  if (out_free) begin
                     res_valid = 1'b1;
                     state_in  = S_IDLE;
                     if (occ_ff == FULL) begin
                        res.status = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = next_slot(tail_ff);
                        occ_in  = occ_ff + 1'b1;
                     end
                  end
               end
               ACT_DEQUEUE, ACT_SEARCH: begin
                  if (occ_ff == '0) begin
                     if (out_free) begin
                        res_valid  = 1'b1;
                        res.status = ST_EMPTY;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     rd_en = 1'b1;
                     if (act_ff == ACT_DEQUEUE) begin
                        state_in = S_DEQ;
                     end else begin
                        pos_in   = next_slot(head_ff);
                        cnt_in   = CW'(1);
                        state_in = S_SRCH;
                     end
                  end
               end
               default: begin
                  if (out_free) begin
                     res_valid = 1'b1;
                     state_in  = S_IDLE;
                  end
               end
            endcase
         end
         S_DEQ: begin
            if (out_free) begin
               res_valid    = 1'b1;
               res.out_byte = rd_data;
               head_in      = next_slot(head_ff);
               occ_in       = occ_ff - 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SRCH: begin
            if (rd_data == data_ff) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  res.found = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (cnt_ff == occ_ff) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = pos_ff;
               pos_in  = next_slot(pos_ff);
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      data_ff <= data_in;
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
   end

   `BFS_ASSERT_IMPL(a_occ_bound, clock, reset, 1'b1, occ_ff <= FULL, "occupancy above depth")
   `BFS_ASSERT_IMPL(a_wr_not_full, clock, reset, wr_en, occ_ff < FULL, "write into full queue")
   `BFS_ASSERT_IMPL(a_rd_wr_excl, clock, reset, wr_en, !rd_en, "read and write together")
   `BFS_ASSERT_IMPL(a_res_room, clock, reset, res_valid, out_free, "result with no room")
   `BFS_ASSERT_IMPL(a_walk_bound, clock, reset, state_ff == S_SRCH,
                    (cnt_ff <= occ_ff) && (cnt_ff != '0), "search walk out of range")
   `BFS_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready,
                    state_ff == S_EXEC, "accepted item not executed")

endmodule

>>> tb/sv/byte_fifo_reply_checker.sv
`timescale 1ns / 1ps

module byte_fifo_reply_checker
   import bfs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_found,
   input  logic [1:0] rsp_status,
   output int         mismatch_count,
   output int         awaited_count
);

   logic [7:0] queued_bytes [DEPTH];
   int         front_slot;
   int         free_slot;
   int         held_count;
   int         replies_seen;
   res_type    pending_replies [$];

   function automatic res_type predict_reply(input logic [1:0] action, input logic [7:0] value);
      res_type reply;
      int      pos;
      reply = '0;
      reply.status = ST_OK;
      case (action)
         ACT_ENQUEUE: begin
            if (held_count >= DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               queued_bytes[free_slot] = value;
               free_slot = (free_slot + 1) % DEPTH;
               held_count++;
            end
         end
         ACT_DEQUEUE: begin
            if (held_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               reply.out_byte = queued_bytes[front_slot];
               front_slot = (front_slot + 1) % DEPTH;
               held_count--;
            end
         end
         ACT_SEARCH: begin
            if (held_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               pos = front_slot;
               for (int n = 0; n < held_count; n++) begin
                  if (queued_bytes[pos] == value)
                     reply.found = 1'b1;
                  pos = (pos + 1) % DEPTH;
               end
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      res_type got;
      res_type want;
      if (reset) begin
         front_slot = 0;
         free_slot = 0;
         held_count = 0;
         pending_replies.delete();
         awaited_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.out_byte = rsp_out_byte;
            got.found = rsp_found;
            got.status = rsp_status;
            if (pending_replies.size() == 0) begin
               if (mismatch_count < 10)
                  $display("result %0d with no item pending: out_byte %h found %b status %0d",
                           replies_seen, got.out_byte, got.found, got.status);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               if (got !== want) begin
                  if (mismatch_count < 10) begin
                     $display("result %0d mismatch: expected out_byte %h found %b status %0d,",
                              replies_seen, want.out_byte, want.found, want.status);
                     $display("   got out_byte %h found %b status %0d",
                              got.out_byte, got.found, got.status);
                  end
                  mismatch_count++;
               end
            end
            replies_seen++;
         end
         if (req_valid && req_ready)
            pending_replies.push_back(predict_reply(req_action, req_data_byte));
         awaited_count = pending_replies.size();
      end
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import bfs_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int LONG_HOLD = 300;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_found;
   logic [1:0] rsp_status;
   int         mismatch_count;
   int         awaited_count;
   int         holds_asked;
   int         holds_done;

   byte_fifo_with_search dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_found     (rsp_found),
      .rsp_status    (rsp_status)
   );

   byte_fifo_reply_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("byte_fifo_with_search verification failed");
      $finish;
   end

   task automatic send_item(input logic [1:0] action, input logic [7:0] value);
      req_valid <= 1'b1;
      req_action <= action;
      req_data_byte <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_all_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (awaited_count == 0);
   endtask

   // receiver: random readiness regimes, plus long hold-offs on request
   initial begin : receiver
      int regime_left;
      int ready_pct;
      regime_left = 0;
      ready_pct = 100;
      holds_done = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < holds_asked) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
            holds_done++;
         end else begin
            if (regime_left == 0) begin
               regime_left = $urandom_range(20, 200);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 70;
                  2: ready_pct = 35;
                  default: ready_pct = 10;
               endcase
            end
            regime_left--;
            rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   initial begin : stimulus
      int         burst_left;
      int         gap;
      int         roll;
      int         enq_pct;
      int         deq_pct;
      bit         narrow;
      logic [1:0] act;
      logic [7:0] val;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_ENQUEUE;
      req_data_byte = 8'h00;
      holds_asked = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty queue cases and the unused code
      send_item(ACT_SEARCH, 8'h00);
      send_item(ACT_DEQUEUE, 8'hFF);
      send_item(ACT_UNUSED, 8'hFF);
      // fill to capacity, then overflow
      for (int k = 0; k < 16; k++)
         send_item(ACT_ENQUEUE, 8'(k * 17));
      send_item(ACT_ENQUEUE, 8'h42);
      send_item(ACT_SEARCH, 8'hFF);
      send_item(ACT_SEARCH, 8'h00);
      send_item(ACT_SEARCH, 8'h42);
      send_item(ACT_DEQUEUE, 8'h00);
      wait_all_replies();

      burst_left = $urandom_range(1, 24);
      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 3)
            0: begin
               enq_pct = 60;
               deq_pct = 12;
            end
            1: begin
               enq_pct = 35;
               deq_pct = 35;
            end
            default: begin
               enq_pct = 12;
               deq_pct = 60;
            end
         endcase
         narrow = $urandom_range(0, 1);
         if (phase == 6)
            wait_all_replies();
         if (phase == 3 || phase == 7)
            holds_asked <= holds_asked + 1;
         for (int k = 0; k < 110; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
               act = ACT_UNUSED;
            else if (roll < 3 + enq_pct)
               act = ACT_ENQUEUE;
            else if (roll < 3 + enq_pct + deq_pct)
               act = ACT_DEQUEUE;
            else
               act = ACT_SEARCH;
            if (!narrow)
               val = 8'($urandom);
            else if ($urandom_range(0, 7) == 0)
               val = 8'($urandom_range(248, 255));
            else
               val = 8'($urandom_range(0, 11));
            send_item(act, val);
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
         end
      end

      wait_all_replies();
      repeat (24) @(posedge clock);
      if (mismatch_count == 0)
         $display("byte_fifo_with_search verification clean");
      else
         $display("byte_fifo_with_search verification failed");
      $finish;
   end

endmodule
